// ===== hdl/bwac_pkg.sv =====
// types and constants for the bit-weighted adc calibration core
// no dependencies; used by bit_weighted_adc_calibration_core
package bwac_pkg;

  localparam int unsigned CalW    = 32;
  localparam int unsigned ThrW    = 16;
  localparam int unsigned IdxW    = 5;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [ThrW-1:0] ThrReset = 16'h8000;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgCalEnable   = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgHiThreshold = 8'd1;

  // input word kinds
  localparam logic FuncConvert = 1'b0;
  localparam logic FuncWrite   = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StFin
  } state_e;

endpackage

// ===== hdl/bit_weighted_adc_calibration_core.sv =====
// bit-weighted adc calibration core: sequencer, shared add/subtract unit and table memory
// depends on bwac_pkg

// Converts a raw READING_BITS-wide reading into a 32-bit calibrated value
// (sum of the table weights of all set reading bits minus the table offset,
// modulo 2^32), taken from the high table when the reading is at or above
// hi_threshold and from the low table otherwise. Both tables sit in one small
// memory and are loaded with table-write words; an entry must be written before
// a conversion reads it. With calibration disabled the reading is returned
// shifted to the top of the 32-bit result. A convert word is accepted, then
// one adder and one table read per cycle walk the offset and all weights;
// pass-through and full-scale words skip the walk. No new word is accepted
// until the finished result is loaded into the output register, where it
// waits, and a stalled output holds the sequencer in its final step.
module bit_weighted_adc_calibration_core #(
  parameter int unsigned READING_BITS = 16
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  // tdata: reading, table_index, table_word
  input  logic [((READING_BITS+bwac_pkg::IdxW+bwac_pkg::CalW+7)/8)*8-1:0] s_axis_tdata,
  // tuser: func, table_select
  input  logic [1:0]                                 s_axis_tuser,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // tdata: calibrated
  output logic [bwac_pkg::CalW-1:0]                  m_axis_tdata,
  // tuser: full_scale
  output logic                                       m_axis_tuser,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  input  logic                                       cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  logic [bwac_pkg::CfgIdxW-1:0]               cfg_index_i,
  input  logic [bwac_pkg::CalW-1:0]                  cfg_data_i
);

  localparam int unsigned Depth  = READING_BITS + 1;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned CntW   = $clog2(READING_BITS + 2);
  localparam int unsigned CmpW   = (READING_BITS > bwac_pkg::ThrW) ? READING_BITS
                                                                    : bwac_pkg::ThrW;
  localparam int unsigned PassW  = bwac_pkg::CalW - READING_BITS;
  localparam int unsigned IdxLo  = READING_BITS;
  localparam int unsigned WordLo = READING_BITS + bwac_pkg::IdxW;

  localparam logic [CntW-1:0] CntFirst = CntW'(1);
  localparam logic [CntW-1:0] CntLast  = CntW'(READING_BITS + 1);
  localparam logic [READING_BITS-1:0] FullScaleCode = {1'b0, {(READING_BITS-1){1'b1}}};

  // input fields
  logic [READING_BITS-1:0]       in_reading;
  logic [bwac_pkg::IdxW-1:0]     in_index;
  logic [bwac_pkg::CalW-1:0]     in_word;
  logic                          in_func;
  logic                          in_sel;

  assign in_reading = s_axis_tdata[READING_BITS-1:0];
  assign in_index   = s_axis_tdata[IdxLo +: bwac_pkg::IdxW];
  assign in_word    = s_axis_tdata[WordLo +: bwac_pkg::CalW];
  assign in_func    = s_axis_tuser[0];
  assign in_sel     = s_axis_tuser[1];

  bwac_pkg::state_e state_q, state_d;

  logic                          cal_en_q;
  logic [bwac_pkg::ThrW-1:0]     thr_q;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic [READING_BITS-1:0]       rd_q, rd_d;
  logic                          tsel_q, tsel_d;
  logic [bwac_pkg::CalW-1:0]     acc_q, acc_d;
  logic                          fs_q, fs_d;
  logic [bwac_pkg::CalW-1:0]     out_data_q;
  logic                          out_fs_q;
  logic                          out_valid_q, out_valid_d;

  logic                          in_acc;
  logic                          is_convert;
  logic                          tab_we;
  logic                          out_load;
  logic                          use_high;
  logic                          full_code;

  // table memory: low table in the lower half, high table in the upper half
  logic [bwac_pkg::CalW-1:0]     tab_mem [2**(AddrW+1)];
  logic [AddrW:0]                rd_addr;
  logic [bwac_pkg::CalW-1:0]     rdata_q;

  // shared add/subtract unit
  logic                          sub_op;
  logic [bwac_pkg::CalW-1:0]     add_b;
  logic [bwac_pkg::CalW-1:0]     add_sum;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_en_q <= 1'b0;
      thr_q    <= bwac_pkg::ThrReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bwac_pkg::CfgCalEnable:   cal_en_q <= cfg_data_i[0];
        bwac_pkg::CfgHiThreshold: thr_q    <= cfg_data_i[bwac_pkg::ThrW-1:0];
        default: ;
      endcase
    end
  end

  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign is_convert = in_acc && (in_func == bwac_pkg::FuncConvert);
  assign tab_we     = in_acc && (in_func == bwac_pkg::FuncWrite)
                      && (in_index <= bwac_pkg::IdxW'(READING_BITS));
  assign use_high   = CmpW'(in_reading) >= CmpW'(thr_q);
  assign full_code  = in_reading == FullScaleCode;

  assign rd_addr = {tsel_q, cnt_q[AddrW-1:0]};

  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      tab_mem[{in_sel, in_index[AddrW-1:0]}] <= in_word;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= tab_mem[rd_addr];
  end

  // first table word is the offset, subtracted; weights are added for set bits
  assign sub_op  = cnt_q == CntFirst;
  assign add_b   = sub_op ? ~rdata_q : (rd_q[READING_BITS-1] ? rdata_q : '0);
  assign add_sum = acc_q + add_b + bwac_pkg::CalW'(sub_op);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bwac_pkg::StIdle: begin
        if (is_convert) begin
          state_d = (cal_en_q && !full_code) ? bwac_pkg::StRun : bwac_pkg::StFin;
        end
      end
      bwac_pkg::StRun: begin
        if (cnt_q == CntLast) begin
          state_d = bwac_pkg::StFin;
        end
      end
      bwac_pkg::StFin: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = bwac_pkg::StIdle;
        end
      end
      default: state_d = bwac_pkg::StIdle;
    endcase
  end

  // datapath control
  always_comb begin
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    cnt_d         = cnt_q;
    rd_d          = rd_q;
    tsel_d        = tsel_q;
    acc_d         = acc_q;
    fs_d          = fs_q;
    unique case (state_q)
      bwac_pkg::StIdle: begin
        s_axis_tready = 1'b1;
        cnt_d         = '0;
        rd_d          = in_reading;
        tsel_d        = use_high;
        fs_d          = 1'b0;
        acc_d         = '0;
        if (!cal_en_q) begin
          acc_d = {in_reading, {PassW{1'b0}}};
        end else if (full_code) begin
          acc_d = '1;
          fs_d  = 1'b1;
        end
      end
      bwac_pkg::StRun: begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q != '0) begin
          acc_d = add_sum;
        end
        if (cnt_q > CntFirst) begin
          rd_d = rd_q << 1;
        end
      end
      bwac_pkg::StFin: begin
        out_load = !out_valid_q || m_axis_tready;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bwac_pkg::StIdle;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q   <= rd_d;
    tsel_q <= tsel_d;
    acc_q  <= acc_d;
    fs_q   <= fs_d;
    if (out_load) begin
      out_data_q <= acc_q;
      out_fs_q   <= fs_q;
    end
  end

  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_fs_q;
  assign m_axis_tvalid = out_valid_q;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bwac_pkg::StRun) |-> (cnt_q <= CntLast))
    else $error("table walk counter past last weight");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == bwac_pkg::StFin))
    else $error("result word loaded outside final step");

  a_fs_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '1))
    else $error("full-scale result not all ones");

  a_convert_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_convert |=> (state_q != bwac_pkg::StIdle))
    else $error("convert word dropped by sequencer");

  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != bwac_pkg::StIdle) |-> !tab_we)
    else $error("table written during a conversion");
`endif

endmodule
